@@ rtl/dmwc_pkg.sv @@
// Package for the direct-mapped write-back cache tag controller.
// Holds the controller state type and the counter width; no dependencies.
`default_nettype none

package dmwc_pkg;

    localparam int CNT_W = 32;

    typedef enum logic
    {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

endpackage

`default_nettype wire

@@ rtl/dmwc_tag_ram.sv @@
// Tag/dirty store: one write port, one read port with registered read data.
// Contents are undefined until written; no dependencies.
`default_nettype none

module dmwc_tag_ram #(
    parameter int DEPTH  = 128,
    parameter int WIDTH  = 21,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/direct_mapped_writeback_cache_tags.sv @@
// Tag controller of a direct-mapped, write-back, write-allocate cache.
// Done is registered from the lookup state that is entered when the start word is taken.
// A new word is taken only while busy is low; busy covers the lookup, which compares
// the tag RAM read data and, on a miss or a write hit, rewrites the same line's entry.
// Reset clears valid bits, controller state and counters at once; the tag RAM
// holds no reset value and needs no clearing pass.
`default_nettype none

module direct_mapped_writeback_cache_tags #(
    parameter int LINE_COUNT     = 128,
    parameter int OFFSET_BITS    = 5,
    parameter int ADDRESS_BITS   = 32,
    localparam int LINE_W        = $clog2(LINE_COUNT),
    localparam int BLK_W         = ADDRESS_BITS - OFFSET_BITS,
    localparam int TAG_W         = ADDRESS_BITS - OFFSET_BITS - LINE_W
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [ADDRESS_BITS-1:0]    address,
    input  wire logic                       is_write,
    output logic                            done,
    output logic [OFFSET_BITS-1:0]          byte_offset,
    output logic [BLK_W-1:0]                block_number,
    output logic [LINE_W-1:0]               line_index,
    output logic [TAG_W-1:0]                tag_value,
    output logic                            miss,
    output logic                            fetch_block,
    output logic                            write_back,
    output logic                            replacement,
    output logic [TAG_W-1:0]                evicted_tag,
    output logic [dmwc_pkg::CNT_W-1:0]      hit_total,
    output logic [dmwc_pkg::CNT_W-1:0]      miss_total,
    output logic [dmwc_pkg::CNT_W-1:0]      access_total
);

    localparam int ENT_W = TAG_W + 1;

    dmwc_pkg::state_t state_reg, state_next;

    logic [ADDRESS_BITS-1:0]      addr_reg;
    logic                         wr_reg;
    logic [LINE_COUNT-1:0]        valid_reg;
    logic                         done_reg;
    logic                         miss_reg;
    logic                         wb_reg;
    logic                         repl_reg;
    logic [TAG_W-1:0]             evict_reg;
    logic [dmwc_pkg::CNT_W-1:0]   hit_reg;
    logic [dmwc_pkg::CNT_W-1:0]   miss_cnt_reg;
    logic [dmwc_pkg::CNT_W-1:0]   acc_reg;

    logic                         accept;
    logic                         lookup;
    logic [LINE_W-1:0]            line_cur;
    logic [TAG_W-1:0]             tag_cur;
    logic [ENT_W-1:0]             rd_ent;
    logic [TAG_W-1:0]             rd_tag;
    logic                         rd_dirty;
    logic                         line_valid;
    logic                         is_miss;
    logic                         ram_we;

    assign accept     = start && !busy;
    assign lookup     = (state_reg == dmwc_pkg::ST_LOOKUP);
    assign line_cur   = addr_reg[OFFSET_BITS +: LINE_W];
    assign tag_cur    = addr_reg[ADDRESS_BITS-1 -: TAG_W];
    assign rd_tag     = rd_ent[TAG_W-1:0];
    assign rd_dirty   = rd_ent[TAG_W];
    assign line_valid = valid_reg[line_cur];
    assign is_miss    = !line_valid || (rd_tag != tag_cur);
    // a miss fills the line; a write hit only sets dirty, tag unchanged
    assign ram_we     = lookup && (is_miss || wr_reg);

    dmwc_tag_ram #(
        .DEPTH (LINE_COUNT),
        .WIDTH (ENT_W)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (line_cur),
        .wdata ({wr_reg, tag_cur}),
        .re    (accept),
        .raddr (address[OFFSET_BITS +: LINE_W]),
        .rdata (rd_ent)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmwc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        unique case (state_reg)
            dmwc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = dmwc_pkg::ST_LOOKUP;
                end
            end
            dmwc_pkg::ST_LOOKUP:
            begin
                busy       = 1'b1;
                state_next = dmwc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dmwc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            done_reg     <= 1'b0;
            hit_reg      <= '0;
            miss_cnt_reg <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            done_reg <= lookup;
            if (lookup)
            begin
                acc_reg <= acc_reg + 1'b1;
                if (is_miss)
                begin
                    valid_reg[line_cur] <= 1'b1;
                    miss_cnt_reg        <= miss_cnt_reg + 1'b1;
                end
                else
                begin
                    hit_reg <= hit_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= address;
            wr_reg   <= is_write;
        end
        if (lookup)
        begin
            miss_reg  <= is_miss;
            wb_reg    <= is_miss && line_valid && rd_dirty;
            repl_reg  <= is_miss && line_valid;
            evict_reg <= (is_miss && line_valid) ? rd_tag : '0;
        end
    end

    assign done         = done_reg;
    assign byte_offset  = addr_reg[OFFSET_BITS-1:0];
    assign block_number = addr_reg[ADDRESS_BITS-1:OFFSET_BITS];
    assign line_index   = line_cur;
    assign tag_value    = tag_cur;
    assign miss         = miss_reg;
    assign fetch_block  = miss_reg;
    assign write_back   = wb_reg;
    assign replacement  = repl_reg;
    assign evicted_tag  = evict_reg;
    assign hit_total    = hit_reg;
    assign miss_total   = miss_cnt_reg;
    assign access_total = acc_reg;

endmodule

`default_nettype wire

@@ rtl/dmwc_checker.sv @@
// Port-level checker for the cache tag controller, bound to the top level.
// Depends on dmwc_pkg and direct_mapped_writeback_cache_tags.
`default_nettype none

module dmwc_checker #(
    parameter int TAG_W = 20
) (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     start,
    input wire logic                     busy,
    input wire logic                     done,
    input wire logic                     miss,
    input wire logic                     fetch_block,
    input wire logic                     write_back,
    input wire logic                     replacement,
    input wire logic [TAG_W-1:0]         evicted_tag,
    input wire logic [dmwc_pkg::CNT_W-1:0] hit_total,
    input wire logic [dmwc_pkg::CNT_W-1:0] miss_total,
    input wire logic [dmwc_pkg::CNT_W-1:0] access_total
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("done did not follow lookup");

    a_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        done && !miss |-> !fetch_block && !write_back && !replacement
            && (evicted_tag == '0))
        else $error("miss-only flags set on a hit");

    a_wb_repl: assert property (@(posedge clk) disable iff (!rst_n)
        done && write_back |-> replacement && miss)
        else $error("write-back without replacement");

    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> access_total == dmwc_pkg::CNT_W'(hit_total + miss_total))
        else $error("access total differs from hit plus miss");

endmodule

bind direct_mapped_writeback_cache_tags dmwc_checker #(
    .TAG_W (TAG_W)
) u_dmwc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .miss         (miss),
    .fetch_block  (fetch_block),
    .write_back   (write_back),
    .replacement  (replacement),
    .evicted_tag  (evicted_tag),
    .hit_total    (hit_total),
    .miss_total   (miss_total),
    .access_total (access_total)
);

`default_nettype wire
